>>> rtl/mwpo_pkg.sv
// ----------------------------------------------------------------------------
// mwpo_pkg: shared types and codes of the multi-waveform phase oscillator
// Holds the register indexes, the waveform codes, the sequencer states and
// the control groups that run between the sequencer and its datapath units.
// ----------------------------------------------------------------------------
package mwpo_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [1:0] REG_WAVEFORM   = 2'd1;
    localparam logic [1:0] REG_AMPLITUDE  = 2'd2;

    // Configuration port widths
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // Input word: envelope level, unsigned Q1.15
    localparam int ENV_W  = 16;
    localparam int AMP_W  = 16;
    localparam int STEP_W = 32;

    // Waveform magnitude: at most 2^30, so 31 bits
    localparam int MAG_W  = 31;
    // Full product magnitude * amplitude * envelope
    localparam int PROD_W = MAG_W + AMP_W + ENV_W;
    // Fraction bits of the product (Q30 * Q12 * Q15)
    localparam int PROD_FRAC = 57;

    // Reset values of the registers
    localparam logic [STEP_W-1:0] PHASE_STEP_RST = 32'd39370534;
    localparam logic [AMP_W-1:0]  AMPLITUDE_RST  = 16'd4096;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SAW      = 2'd1,
        WAVE_SQUARE   = 2'd2,
        WAVE_TRIANGLE = 2'd3
    } wave_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAVE,
        ST_MUL_AMP,
        ST_MUL_ENV,
        ST_ROUND
    } seq_state_t;

    // Phase and waveform unit controls
    typedef struct packed {
        logic advance;   // step the phase accumulator
        logic capture;   // register the waveform magnitude and sign
    } wave_ctrl_t;

    // Shared multiplier controls
    typedef struct packed {
        logic load_amp;  // product = magnitude * amplitude
        logic load_env;  // product = product * envelope
    } mul_ctrl_t;

endpackage

>>> rtl/mwpo_wave.sv
// ----------------------------------------------------------------------------
// mwpo_wave: phase accumulator and waveform lookup
// Advances the phase by the step register, wrapping modulo one cycle, and
// turns the phase into the magnitude and sign of a sine, saw, square or
// triangle value in Q30. The sine comes from a quarter-wave constant table.
// ----------------------------------------------------------------------------
module mwpo_wave #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mwpo_pkg::wave_ctrl_t        ctrl,
    input  logic [mwpo_pkg::STEP_W-1:0] phase_step,
    input  mwpo_pkg::wave_t             waveform,
    output logic [mwpo_pkg::MAG_W-1:0]  mag,
    output logic                        neg
);
    import mwpo_pkg::*;

    localparam int QBITS   = SINE_TABLE_BITS - 2;
    localparam int QUARTER = 1 << QBITS;
    localparam int WIDE_W  = PHASE_BITS + 32;
    localparam int XR_W    = SINE_TABLE_BITS - 1;
    localparam logic signed [33:0] ONE   = 34'sd1073741824;
    localparam logic signed [33:0] THREE = 34'sd3221225472;

    // Taylor coefficients of sin(pi/2 * x), Q30
    localparam longint COEF0 = 64'sd1686629713;
    localparam longint COEF1 = -64'sd693598671;
    localparam longint COEF2 = 64'sd85569306;
    localparam longint COEF3 = -64'sd5026995;
    localparam longint COEF4 = 64'sd172273;

    // a * b / 2^30, truncated toward zero
    function automatic longint mul_q30(input longint a, input longint unsigned b);
        longint unsigned m;
        if (a < 0)
        begin
            m = (longint'(-a) * b) >> 30;
            return -longint'(m);
        end
        m = (longint'(a) * b) >> 30;
        return longint'(m);
    endfunction

    // Table entry for quarter-wave index xr, rounded to Q15
    function automatic logic [15:0] sine_entry(input int unsigned xr);
        longint unsigned x;
        longint unsigned x2;
        longint          p;
        longint          s;
        longint          e;
        x  = longint'(xr) << (30 - QBITS);
        x2 = (x * x) >> 30;
        p  = COEF4;
        p  = COEF3 + mul_q30(p, x2);
        p  = COEF2 + mul_q30(p, x2);
        p  = COEF1 + mul_q30(p, x2);
        p  = COEF0 + mul_q30(p, x2);
        s  = mul_q30(p, x);
        if (s < 0)
        begin
            s = 0;
        end
        e = (s + 64'sd16384) >>> 15;
        if (e > 32768)
        begin
            e = 32768;
        end
        return e[15:0];
    endfunction

    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [PHASE_BITS-1:0] phase_acc_next;
    logic [MAG_W-1:0]      mag_reg;
    logic [MAG_W-1:0]      mag_next;
    logic                  neg_reg;
    logic                  neg_next;

    logic [15:0]           sine_rom [QUARTER+1];
    logic [WIDE_W-1:0]     wide;
    logic [SINE_TABLE_BITS-1:0] k;
    logic [1:0]            quad;
    logic [XR_W-1:0]       r_ext;
    logic [XR_W-1:0]       xr;
    logic [15:0]           sine_e;
    logic [30:0]           top31;
    logic [31:0]           top32;
    logic signed [33:0]    w;
    logic signed [33:0]    w_abs;

    // Build the quarter-wave table at elaboration
    for (genvar i = 0; i <= QUARTER; i++)
    begin : g_rom
        assign sine_rom[i] = sine_entry(i);
    end

    // Advance the phase, wrapping modulo one cycle
    assign phase_acc_next = ctrl.advance ? phase_acc_reg + PHASE_BITS'(phase_step)
                                         : phase_acc_reg;

    // Top bits of the phase, zero-filled below when the phase is narrow
    assign wide  = {phase_acc_reg, 32'd0};
    assign k     = wide[WIDE_W-1 -: SINE_TABLE_BITS];
    assign top31 = wide[WIDE_W-1 -: 31];
    assign top32 = wide[WIDE_W-1 -: 32];

    // Fold the phase into the first quadrant
    assign quad   = k[SINE_TABLE_BITS-1 -: 2];
    assign r_ext  = XR_W'(k[QBITS-1:0]);
    assign xr     = quad[0] ? XR_W'(QUARTER) - r_ext : r_ext;
    assign sine_e = sine_rom[xr];

    // Select the waveform value in signed Q30
    always_comb
    begin
        case (waveform)
            WAVE_SINE:
            begin
                w = quad[1] ? -$signed({3'd0, sine_e, 15'd0})
                            : $signed({3'd0, sine_e, 15'd0});
            end
            WAVE_SAW:
            begin
                w = $signed({3'd0, top31}) - ONE;
            end
            WAVE_SQUARE:
            begin
                w = top32[31] ? ONE : -ONE;
            end
            default:
            begin
                w = top32[31] ? THREE - $signed({2'd0, top32})
                              : $signed({2'd0, top32}) - ONE;
            end
        endcase
    end

    // Split into sign and magnitude
    assign w_abs    = w[33] ? -w : w;
    assign neg_next = ctrl.capture ? w[33] : neg_reg;
    assign mag_next = ctrl.capture ? w_abs[MAG_W-1:0] : mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
        end
        else
        begin
            phase_acc_reg <= phase_acc_next;
        end
    end

    // Hold the waveform value for the multiplier
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        neg_reg <= neg_next;
    end

    assign mag = mag_reg;
    assign neg = neg_reg;

endmodule

>>> rtl/mwpo_mul.sv
// ----------------------------------------------------------------------------
// mwpo_mul: shared gain multiplier
// One 47 x 16 multiplier applied twice per sample: first the waveform
// magnitude by the amplitude, then that product by the envelope level.
// ----------------------------------------------------------------------------
module mwpo_mul (
    input  logic                        clk,
    input  mwpo_pkg::mul_ctrl_t         ctrl,
    input  logic [mwpo_pkg::MAG_W-1:0]  mag,
    input  logic [mwpo_pkg::AMP_W-1:0]  amplitude,
    input  logic [mwpo_pkg::ENV_W-1:0]  envelope_level,
    output logic [mwpo_pkg::PROD_W-1:0] product
);
    import mwpo_pkg::*;

    localparam int OPA_W = MAG_W + AMP_W;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [OPA_W-1:0]  opa;
    logic [ENV_W-1:0]  opb;
    logic [PROD_W-1:0] mul_out;

    // Pick the operands for this pass
    assign opa     = ctrl.load_env ? prod_reg[OPA_W-1:0] : OPA_W'(mag);
    assign opb     = ctrl.load_env ? envelope_level : amplitude;
    assign mul_out = PROD_W'(opa * opb);

    assign prod_next = (ctrl.load_amp || ctrl.load_env) ? mul_out : prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign product = prod_reg;

endmodule

>>> rtl/multi_waveform_phase_oscillator_core.sv
// ----------------------------------------------------------------------------
// multi_waveform_phase_oscillator_core: DDS oscillator with gain
// Steps: the accept state advances the phase, then the waveform lookup, two
// passes through the shared multiplier and the rounding step follow in turn;
// a held output word stalls the rounding step until taken. The rounding step
// loads the output word; a new input word is taken only back in idle.
// Reset: phase cleared, registers to their defaults, no output pending.
// ----------------------------------------------------------------------------
module multi_waveform_phase_oscillator_core #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port
    input  logic                                 cfg_we,
    input  logic [mwpo_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mwpo_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [15:0]                          s_tdata,   // [15:0] envelope_level
    // Output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata    // [SAMPLE_BITS-1:0] sample
);
    import mwpo_pkg::*;

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int SH      = PROD_FRAC + 1 - SAMPLE_BITS;
    localparam int RES_W   = 64 - SH;
    localparam logic [63:0]      HALF  = 64'd1 << (SH - 1);
    localparam logic [RES_W-1:0] LIMIT = RES_W'(1) << (SAMPLE_BITS - 1);

    seq_state_t              state_reg;
    seq_state_t              state_next;
    logic [STEP_W-1:0]       phase_step_reg;
    wave_t                   waveform_reg;
    logic [AMP_W-1:0]        amplitude_reg;
    logic [ENV_W-1:0]        env_reg;
    logic [ENV_W-1:0]        env_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [SAMPLE_BITS-1:0]  sample_reg;
    logic [SAMPLE_BITS-1:0]  sample_next;

    wave_ctrl_t              wave_ctrl;
    mul_ctrl_t               mul_ctrl;
    logic [MAG_W-1:0]        mag;
    logic                    neg;
    logic [PROD_W-1:0]       product;
    logic                    in_fire;
    logic                    out_load;

    logic [63:0]             round_sum;
    logic [RES_W-1:0]        res;
    logic [RES_W-1:0]        res_sat;
    logic [SAMPLE_BITS-1:0]  sample_calc;

    mwpo_wave #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_wave (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (wave_ctrl),
        .phase_step (phase_step_reg),
        .waveform   (waveform_reg),
        .mag        (mag),
        .neg        (neg)
    );

    mwpo_mul u_mul (
        .clk            (clk),
        .ctrl           (mul_ctrl),
        .mag            (mag),
        .amplitude      (amplitude_reg),
        .envelope_level (env_reg),
        .product        (product)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= PHASE_STEP_RST;
            waveform_reg   <= WAVE_SINE;
            amplitude_reg  <= AMPLITUDE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PHASE_STEP: phase_step_reg <= cfg_data[STEP_W-1:0];
                REG_WAVEFORM:   waveform_reg   <= wave_t'(cfg_data[1:0]);
                REG_AMPLITUDE:  amplitude_reg  <= cfg_data[AMP_W-1:0];
                default:        ;
            endcase
        end
    end

    assign in_fire = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // Sequencer: next state and unit controls
    always_comb
    begin
        state_next = state_reg;
        wave_ctrl  = '0;
        mul_ctrl   = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    wave_ctrl.advance = 1'b1;
                    state_next        = ST_WAVE;
                end
            end
            ST_WAVE:
            begin
                wave_ctrl.capture = 1'b1;
                state_next        = ST_MUL_AMP;
            end
            ST_MUL_AMP:
            begin
                mul_ctrl.load_amp = 1'b1;
                state_next        = ST_MUL_ENV;
            end
            ST_MUL_ENV:
            begin
                mul_ctrl.load_env = 1'b1;
                state_next        = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Latch the envelope with the accepted word
    assign env_next = in_fire ? s_tdata[ENV_W-1:0] : env_reg;

    always_ff @(posedge clk)
    begin
        env_reg <= env_next;
    end

    // Round half away from zero, then saturate to the sample range
    assign round_sum = 64'(product) + HALF;
    assign res       = round_sum[63:SH];

    always_comb
    begin
        if (neg)
        begin
            res_sat     = (res > LIMIT) ? LIMIT : res;
            sample_calc = SAMPLE_BITS'(~res_sat + RES_W'(1));
        end
        else
        begin
            res_sat     = (res > LIMIT - RES_W'(1)) ? LIMIT - RES_W'(1) : res;
            sample_calc = res_sat[SAMPLE_BITS-1:0];
        end
    end

    // Output register: hold the word until taken
    assign out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    assign sample_next    = out_load ? sample_calc : sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(sample_reg);

    // Sequencer stays busy right after a word is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready)
        else $error("input accepted twice in a row");

    // A new output word only comes from the rounding step
    a_out_from_round: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_ROUND))
        else $error("output word raised outside the rounding step");

    // Waveform magnitude never exceeds unity in Q30
    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_AMP) |-> (mag <= MAG_W'(1073741824)))
        else $error("waveform magnitude above full scale");

endmodule

>>> verif/multi_waveform_phase_oscillator_core_tb.sv
// ----------------------------------------------------------------------------
// multi_waveform_phase_oscillator_core_tb: self-checking bench for the DDS core
// Streams envelope words through the oscillator under a series of register
// settings and compares every output sample with a bit-exact software model
// of the phase accumulator, the four waveforms and the saturating gain stage.
// ----------------------------------------------------------------------------
module multi_waveform_phase_oscillator_core_tb;

    import mwpo_pkg::*;

    localparam int          SAMPLE_W      = 16;
    localparam int          IDLE_PCT      = 13;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          TOTAL_WORDS   = 550;
    localparam int          MAX_REPORTS   = 10;
    localparam logic [1:0]  REG_UNUSED    = 2'd3;

    // Fixed-point constants of the waveform math
    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint SIN_C0  = 64'sd1686629713;
    localparam longint SIN_C1  = -64'sd693598671;
    localparam longint SIN_C2  = 64'sd85569306;
    localparam longint SIN_C3  = -64'sd5026995;
    localparam longint SIN_C4  = 64'sd172273;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data  = '0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [15:0]                s_tdata   = '0;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]        m_tdata;

    // Oscillator model state and registers
    logic [STEP_W-1:0]          osc_phase = '0;
    logic [STEP_W-1:0]          osc_step  = PHASE_STEP_RST;
    wave_t                      osc_wave  = WAVE_SINE;
    logic [AMP_W-1:0]           osc_amp   = AMPLITUDE_RST;

    logic [15:0]                envelope_words[$];
    logic [SAMPLE_W-1:0]        predicted_samples[$];
    int                         words_queued  = 0;
    int                         words_taken   = 0;
    int                         mismatches    = 0;
    int                         cycle_count   = 0;
    logic                       word_taken    = 1'b0;
    logic                       no_gaps       = 1'b0;
    int                         hold_requests = 0;
    int                         hold_served   = 0;
    int                         hold_left     = 0;

    multi_waveform_phase_oscillator_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    // a * b / 2^30, truncated toward zero
    function automatic longint q30_scale(input longint a, input longint unsigned b);
        longint unsigned ua;
        longint unsigned m;
        if (a < 0)
        begin
            ua = $unsigned(-a);
            m  = (ua * b) >> 30;
            return -$signed(m);
        end
        ua = $unsigned(a);
        m  = (ua * b) >> 30;
        return $signed(m);
    endfunction

    // Quarter-wave sine from the phase table index, Q30 with the sign applied
    function automatic longint sine_level(input logic [STEP_W-1:0] ph);
        logic [9:0]      idx;
        longint unsigned x;
        longint unsigned x2;
        longint          acc;
        longint          e;
        idx = ph[31:22];
        x   = idx[8] ? (64'd256 - idx[7:0]) : idx[7:0];
        x   = x << 22;
        x2  = (x * x) >> 30;
        acc = SIN_C3 + q30_scale(SIN_C4, x2);
        acc = SIN_C2 + q30_scale(acc, x2);
        acc = SIN_C1 + q30_scale(acc, x2);
        acc = SIN_C0 + q30_scale(acc, x2);
        acc = q30_scale(acc, x);
        if (acc < 0)
            acc = 0;
        e = (acc + 64'sd16384) >>> 15;
        if (e > 32768)
            e = 32768;
        e = e * 32768;
        return idx[9] ? -e : e;
    endfunction

    // Advance the phase and compute the saturated sample for one envelope word
    function automatic logic [SAMPLE_W-1:0] next_sample(input logic [15:0] env);
        longint          w;
        longint          p;
        longint unsigned mag;
        longint unsigned res;
        logic            neg;
        osc_phase = osc_phase + osc_step;
        case (osc_wave)
            WAVE_SINE:   w = sine_level(osc_phase);
            WAVE_SAW:
            begin
                p = osc_phase[31:1];
                w = p - Q30_ONE;
            end
            WAVE_SQUARE: w = osc_phase[31] ? Q30_ONE : -Q30_ONE;
            default:
            begin
                p = osc_phase;
                w = (p < 2 * Q30_ONE) ? (p - Q30_ONE) : (3 * Q30_ONE - p);
            end
        endcase
        neg = (w < 0);
        mag = neg ? $unsigned(-w) : $unsigned(w);
        mag = mag * osc_amp * env;
        res = (mag + (64'd1 << 41)) >> 42;
        if (neg)
        begin
            if (res > 64'd32768)
                res = 64'd32768;
            res = -res;
        end
        else if (res > 64'd32767)
            res = 64'd32767;
        return res[SAMPLE_W-1:0];
    endfunction

    // Mirror a register write into the model
    function automatic void apply_reg(input logic [1:0] idx, input logic [31:0] data);
        case (idx)
            REG_PHASE_STEP: osc_step = data;
            REG_WAVEFORM:   osc_wave = wave_t'(data[1:0]);
            REG_AMPLITUDE:  osc_amp  = data[15:0];
            default:        ;
        endcase
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_reg(idx, data);
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic offer(input logic [15:0] env);
        envelope_words.push_back(env);
        words_queued++;
    endtask

    // Wait until every word is taken and every sample has come back
    task automatic settle();
        while (words_taken != words_queued || predicted_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Input driver: offer the next word, or idle now and then
    always @(negedge clk)
    begin
        if (!s_tvalid || word_taken)
        begin
            if (envelope_words.size() != 0 &&
                (no_gaps || $urandom_range(99) >= IDLE_PCT))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= envelope_words.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Output receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= no_gaps || $urandom_range(99) >= IDLE_PCT;
    end

    // Monitor: predict on each input word, check each output word
    always @(posedge clk)
    begin
        logic [SAMPLE_W-1:0] want;
        word_taken <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
        begin
            predicted_samples.push_back(next_sample(s_tdata));
            words_taken++;
        end
        if (m_tvalid && m_tready)
        begin
            if (predicted_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected sample %0d", $signed(m_tdata));
            end
            else
            begin
                want = predicted_samples.pop_front();
                if (m_tdata !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("sample mismatch: expected %0d, got %0d",
                                 $signed(want), $signed(m_tdata));
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("multi_waveform_phase_oscillator_core test failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          phase_no;
        int          n;
        logic [31:0] step_word;
        logic [31:0] wave_word;
        logic [31:0] amp_word;
        logic [15:0] env;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings, sine: envelope extremes
        offer(16'h8000);
        offer(16'hFFFF);
        offer(16'h0000);
        offer(16'h0001);
        settle();

        // Stray index is dropped, wide values are trimmed; saw across the wrap
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        write_reg(REG_PHASE_STEP, 32'h4000_0000);
        write_reg(REG_WAVEFORM, 32'hFFFF_FFFD);
        write_reg(REG_AMPLITUDE, 32'hABCD_1000);
        end_writes();
        repeat (5) offer(16'h8000);
        settle();

        // Square at maximum gain: saturation on both rails
        write_reg(REG_WAVEFORM, {30'd0, WAVE_SQUARE});
        write_reg(REG_PHASE_STEP, 32'h8000_0000);
        write_reg(REG_AMPLITUDE, 32'h0000_FFFF);
        end_writes();
        offer(16'hFFFF);
        offer(16'hFFFF);
        offer(16'h8000);
        offer(16'h0000);
        settle();

        // Triangle with zero gain and a full-scale step
        write_reg(REG_WAVEFORM, {30'd0, WAVE_TRIANGLE});
        write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
        write_reg(REG_AMPLITUDE, 32'h0000_0000);
        end_writes();
        offer(16'hFFFF);
        offer(16'd12345);
        settle();

        // Triangle corners at unity gain
        write_reg(REG_PHASE_STEP, 32'h2000_0000);
        write_reg(REG_AMPLITUDE, {16'd0, AMPLITUDE_RST});
        end_writes();
        repeat (5) offer(16'h8000);
        settle();

        // Sine one table entry per word, near full scale
        write_reg(REG_WAVEFORM, {30'd0, WAVE_SINE});
        write_reg(REG_PHASE_STEP, 32'h0040_0000);
        write_reg(REG_AMPLITUDE, 32'h0000_FFFF);
        end_writes();
        repeat (3) offer(16'h8000);

        // Random phases: new settings each time, waveforms in turn
        phase_no = 0;
        while (words_queued < TOTAL_WORDS)
        begin
            settle();
            if ($urandom_range(3) == 0)
                write_reg(REG_UNUSED, $urandom);
            case ($urandom_range(7))
                0:       step_word = 32'h0000_0000;
                1:       step_word = 32'hFFFF_FFFF;
                2:       step_word = $urandom_range(1, 32'h0100_0000);
                3:       step_word = -$urandom_range(1, 32'h0100_0000);
                default: step_word = $urandom;
            endcase
            wave_word      = $urandom;
            wave_word[1:0] = 2'(phase_no);
            amp_word       = $urandom;
            case ($urandom_range(5))
                0:       amp_word[15:0] = 16'h0000;
                1:       amp_word[15:0] = 16'hFFFF;
                2:       amp_word[15:0] = AMPLITUDE_RST;
                default: amp_word[15:0] = $urandom_range(65535);
            endcase
            write_reg(REG_PHASE_STEP, step_word);
            write_reg(REG_WAVEFORM, wave_word);
            write_reg(REG_AMPLITUDE, amp_word);
            end_writes();

            no_gaps = (phase_no == 3);
            if (phase_no == 5)
                hold_requests++;

            n = $urandom_range(20, 45);
            repeat (n)
            begin
                case ($urandom_range(9))
                    0:       env = 16'h0000;
                    1:       env = 16'h8000;
                    2:       env = 16'hFFFF;
                    3, 4:    env = $urandom_range(65535);
                    default: env = $urandom_range(32768);
                endcase
                offer(env);
            end
            phase_no++;
        end

        settle();
        if (mismatches == 0 && predicted_samples.size() == 0)
            $display("multi_waveform_phase_oscillator_core test passed");
        else
            $display("multi_waveform_phase_oscillator_core test failed");
        $finish;
    end

endmodule
